// ===== rtl/core/pngu_pkg.sv =====
// shared types, constants and the paeth predictor for the png scanline unfilter
// no dependencies
`timescale 1ns / 1ps

package pngu_pkg;

    localparam int MAX_ROW_BYTES   = 16384;
    localparam int MAX_PIXEL_BYTES = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam int COL_W     = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W     = $clog2(MAX_ROW_BYTES + 1);
    localparam int BPP_W     = 3;
    localparam int BPP_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int CFG_W     = (LEN_W > BPP_W) ? LEN_W : BPP_W;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_BYTES_PER_PIXEL = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_BYTES       = CFG_ADDR_W'(1);

    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(4);
    localparam logic [LEN_W-1:0] ROW_RESET = LEN_W'(1);

    typedef enum logic [2:0] {
        FILT_NONE,
        FILT_SUB,
        FILT_UP,
        FILT_AVG,
        FILT_PAETH
    } filt_t;

    // one data byte, classified by the front end
    typedef struct packed {
        logic [7:0]       data_byte;
        filt_t            filt;
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             last;
    } item_t;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [7:0] res;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/png_scanline_unfilter.sv =====
// top level of the png scanline unfilter: config registers, front end, queue, back end
// depends on pngu_pkg, pngu_front, pngu_queue, pngu_back, pngu_ram
`timescale 1ns / 1ps

// Reconstructs PNG filtered scanlines (None, Sub, Up, Average, Paeth) from the
// decompressed byte stream. One byte is accepted per clock while the queue is
// not full, filter bytes included; a filter byte gives no output, each data
// byte gives one. A data byte passes through the queue, the reconstruction
// stage and the output register before m_tvalid rises for it.
// The prior row lives in a 16384 x 8 line buffer with one write and one read
// each cycle; the byte above is fetched one stage ahead of the reconstruction
// stage, so that the left-byte feedback closes within that stage. A four-entry
// queue separates input from output, so either side may stall. The line
// buffer is not cleared after reset; it is filled by the first row of each
// image. Write bytes_per_pixel (index 0) and row_bytes (index 1) only while
// the block is idle.
module png_scanline_unfilter
    import pngu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] image_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] pixel_byte
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    logic [BPP_W-1:0]     bpp_reg;
    logic [LEN_W-1:0]     row_reg;
    logic [BPP_W-1:0]     bpp_eff;
    logic [LEN_W-1:0]     row_eff;
    logic [BPP_IDX_W-1:0] bpp_idx;

    logic  q_push;
    item_t q_push_item;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    item_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_RESET;
            row_reg <= ROW_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_BYTES_PER_PIXEL) begin
                bpp_reg <= cfg_wdata[BPP_W-1:0];
            end else if (cfg_addr == REG_ROW_BYTES) begin
                row_reg <= cfg_wdata[LEN_W-1:0];
            end
        end
    end

    // zero acts as one, oversize values saturate
    always_comb begin
        priority if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = bpp_reg;
        end
        priority if (row_reg == '0) begin
            row_eff = LEN_W'(1);
        end else if (row_reg > LEN_W'(MAX_ROW_BYTES)) begin
            row_eff = LEN_W'(MAX_ROW_BYTES);
        end else begin
            row_eff = row_reg;
        end
    end

    assign bpp_idx = BPP_IDX_W'(bpp_eff - BPP_W'(1));

    pngu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .row_len (row_eff),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    pngu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_item (q_head)
    );

    pngu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_head),
        .q_pop   (q_pop),
        .bpp_idx (bpp_idx),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

// ===== rtl/core/pngu_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pngu_front.sv =====
// front end: takes the byte stream, tracks filter bytes, columns and rows
// depends on pngu_pkg
`timescale 1ns / 1ps

module pngu_front
    import pngu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tuser,   // [0] image_start
    input  logic [LEN_W-1:0] row_len,
    input  logic             q_full,
    output logic             q_push,
    output item_t            q_item
);

    logic             expect_reg, expect_next;
    logic             first_row_reg, first_row_next;
    logic [COL_W-1:0] col_reg, col_next;
    filt_t            filt_reg, filt_next;

    logic             accept;
    logic             expect_eff;
    logic             first_eff;
    logic             last;
    filt_t            filt_code;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign expect_eff = expect_reg || s_tuser;
    assign first_eff  = first_row_reg || s_tuser;
    assign last       = ({1'b0, col_reg} + (COL_W + 1)'(1)) >= (COL_W + 1)'(row_len);

    // codes above paeth pass bytes through like none
    always_comb begin
        unique case (s_tdata)
            8'd1:    filt_code = FILT_SUB;
            8'd2:    filt_code = FILT_UP;
            8'd3:    filt_code = FILT_AVG;
            8'd4:    filt_code = FILT_PAETH;
            default: filt_code = FILT_NONE;
        endcase
    end

    always_comb begin
        expect_next    = expect_reg;
        first_row_next = first_row_reg;
        col_next       = col_reg;
        filt_next      = filt_reg;
        q_push         = 1'b0;
        if (accept) begin
            if (expect_eff) begin
                filt_next      = filt_code;
                expect_next    = 1'b0;
                col_next       = '0;
                first_row_next = first_eff;
            end else begin
                q_push = 1'b1;
                if (last) begin
                    expect_next    = 1'b1;
                    first_row_next = 1'b0;
                    col_next       = '0;
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    assign q_item = '{data_byte: s_tdata, filt: filt_reg, col: col_reg,
                      first_row: first_row_reg, last: last};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reg    <= 1'b1;
            first_row_reg <= 1'b1;
            col_reg       <= '0;
            filt_reg      <= FILT_NONE;
        end else begin
            expect_reg    <= expect_next;
            first_row_reg <= first_row_next;
            col_reg       <= col_next;
            filt_reg      <= filt_next;
        end
    end

endmodule

// ===== rtl/core/pngu_queue.sv =====
// short fifo of classified data bytes between front end and back end
// depends on pngu_pkg; QUEUE_DEPTH must be a power of two
`timescale 1ns / 1ps

module pngu_queue
    import pngu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

// ===== rtl/core/pngu_back.sv =====
// back end: line buffer read, filter reconstruction and output register
// depends on pngu_pkg and pngu_ram
`timescale 1ns / 1ps

module pngu_back
    import pngu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    input  logic [BPP_IDX_W-1:0] bpp_idx,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] pixel_byte
    output logic                 m_tlast
);

    logic       b2_valid_reg, b2_valid_next;
    item_t      b2_item_reg;
    logic       byp_reg, byp_next;
    logic [7:0] byp_data_reg;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic [7:0] left_reg [MAX_PIXEL_BYTES];
    logic [7:0] upl_reg  [MAX_PIXEL_BYTES];

    logic       out_free;
    logic       b2_fire;
    logic [7:0] ram_rdata;
    logic       row_start;
    logic [7:0] a_byte;
    logic [7:0] b_byte;
    logic [7:0] c_byte;
    logic [8:0] ab_sum;
    logic [7:0] pred;
    logic [7:0] r_byte;

    assign out_free = !m_valid_reg || m_tready;
    assign b2_fire  = b2_valid_reg && out_free;
    assign q_pop    = q_valid && (!b2_valid_reg || b2_fire);

    pngu_ram #(
        .WIDTH(8),
        .DEPTH(MAX_ROW_BYTES)
    ) u_line_buf (
        .aclk (aclk),
        .we   (b2_fire),
        .waddr(b2_item_reg.col),
        .wdata(r_byte),
        .re   (q_pop),
        .raddr(q_item.col),
        .rdata(ram_rdata)
    );

    // left and upper-left neighbours are zero at the start of a row
    assign row_start = (b2_item_reg.col == '0);
    assign a_byte    = row_start ? 8'd0 : left_reg[bpp_idx];
    assign c_byte    = row_start ? 8'd0 : upl_reg[bpp_idx];
    assign b_byte    = b2_item_reg.first_row ? 8'd0 : (byp_reg ? byp_data_reg : ram_rdata);
    assign ab_sum    = {1'b0, a_byte} + {1'b0, b_byte};

    always_comb begin
        unique case (b2_item_reg.filt)
            FILT_SUB:   pred = a_byte;
            FILT_UP:    pred = b_byte;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth_pred(a_byte, b_byte, c_byte);
            default:    pred = 8'd0;
        endcase
        r_byte = b2_item_reg.data_byte + pred;
    end

    always_comb begin
        b2_valid_next = b2_valid_reg;
        if (q_pop) begin
            b2_valid_next = 1'b1;
        end else if (b2_fire) begin
            b2_valid_next = 1'b0;
        end
        // same column written this cycle: the ram read returns stale data
        byp_next = byp_reg;
        if (q_pop) begin
            byp_next = b2_fire && (b2_item_reg.col == q_item.col);
        end else if (b2_fire) begin
            byp_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b2_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            b2_valid_reg <= b2_valid_next;
            byp_reg      <= byp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b2_item_reg  <= q_item;
            byp_data_reg <= r_byte;
        end
        if (b2_fire) begin
            m_data_reg <= r_byte;
            m_last_reg <= b2_item_reg.last;
            left_reg[0] <= r_byte;
            upl_reg[0]  <= b_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                left_reg[i] <= row_start ? 8'd0 : left_reg[i-1];
                upl_reg[i]  <= row_start ? 8'd0 : upl_reg[i-1];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_byp_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_reg |-> b2_valid_reg)
        else $error("bypass flag set with empty stage");

    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && b2_fire && !b2_item_reg.last) |->
            ((q_item.col == b2_item_reg.col + COL_W'(1)) || (q_item.col == '0)))
        else $error("column sequence broken");

    a_fire_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        b2_fire |=> m_valid_reg)
        else $error("result lost at output register");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for png_scanline_unfilter: directed rows, then random images
// depends on pngu_pkg and the png_scanline_unfilter rtl
`timescale 1ns / 1ps

module tb_top;
    import pngu_pkg::*;

    localparam int      DIRECTED_ROWS = 23;
    localparam int      PHASES        = 11;
    localparam int      DRAIN_CYCLES  = 10;
    localparam longint  CYCLE_LIMIT   = 64'd8_000_000;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } pixel_exp_t;

    // one directed transfer; known marks a result typed in by hand
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        bit         known;
        logic [7:0] pixel;
        logic       row_end;
    } dir_row_t;

    typedef struct packed {
        int bpp;
        int row;
        int min_bytes;
        int min_rows;
        int max_rows;
        int src_gap_odds;
        int sink_gap_odds;
    } phase_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] data_byte
    logic                  s_tuser   = 1'b0; // [0] image_start
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] pixel_byte
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // unfilter state mirrored by the testbench
    logic [7:0]                        prior_line [MAX_ROW_BYTES];
    logic [MAX_PIXEL_BYTES-1:0][7:0]   left_hist       = '0;
    logic [MAX_PIXEL_BYTES-1:0][7:0]   above_left_hist = '0;
    int                                col_pos         = 0;
    logic [7:0]                        row_filter      = '0;
    bit                                want_filter     = 1'b1;
    bit                                first_row_flag  = 1'b1;
    logic [BPP_W-1:0]                  cfg_bpp         = BPP_RESET;
    logic [LEN_W-1:0]                  cfg_row         = ROW_RESET;

    pixel_exp_t pending_pixels [$];
    pixel_exp_t head_exp;

    int     src_gap_odds  = 0;
    int     sink_gap_odds = 0;
    int     sink_gap      = 0;
    int     bytes_sent    = 0;
    int     bytes_checked = 0;
    int     reg_writes    = 0;
    int     mismatches    = 0;
    longint cycle_count   = 0;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'(FILT_NONE),  1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hFF,          1'b0, 1'b1, 8'hFF, 1'b1},
        '{8'(FILT_SUB),   1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h00,          1'b0, 1'b1, 8'h00, 1'b1},
        '{8'(FILT_UP),    1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h01,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'(FILT_AVG),   1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'(FILT_PAETH), 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7F,          1'b0, 1'b0, 8'h00, 1'b0},
        // filter codes beyond paeth pass the data through
        '{8'h05,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hAA,          1'b0, 1'b1, 8'hAA, 1'b1},
        '{8'hFF,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h55,          1'b0, 1'b1, 8'h55, 1'b1},
        // average and paeth on the first row of a new image
        '{8'(FILT_AVG),   1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hFE,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'(FILT_PAETH), 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h01,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'(FILT_UP),    1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hFF,          1'b0, 1'b0, 8'h00, 1'b0},
        '{8'(FILT_SUB),   1'b0, 1'b0, 8'h00, 1'b0},
        // image start where a data byte was due turns it into a filter byte
        '{8'h80,          1'b1, 1'b0, 8'h00, 1'b0},
        '{8'h3C,          1'b0, 1'b1, 8'h3C, 1'b1}
    };

    // bpp, row, min bytes, min rows, max rows, sender gap odds, receiver gap odds
    phase_t phase_list [PHASES] = '{
        '{1, 8,     100, 1, 6, 8,  8},
        '{0, 0,     40,  1, 6, 4,  0},
        '{3, 7,     100, 1, 6, 0,  6},
        '{7, 5,     80,  1, 6, 8,  8},
        '{2, 33,    120, 1, 3, 6,  3},
        '{4, 64,    60,  2, 2, 16, 16},
        '{1, 40,    1,   1, 1, 16, 16},
        '{5, 3,     80,  1, 6, 8,  8},
        '{4, 16,    100, 1, 6, 8,  8},
        '{6, 1,     60,  1, 6, 3,  3},
        '{2, 11,    80,  1, 6, 12, 12}
    };

    png_scanline_unfilter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int dist_a;
        int dist_b;
        int dist_c;
        dist_a = int'(b) - int'(c);
        dist_b = int'(a) - int'(c);
        dist_c = int'(a) + int'(b) - 2 * int'(c);
        if (dist_a < 0) dist_a = -dist_a;
        if (dist_b < 0) dist_b = -dist_b;
        if (dist_c < 0) dist_c = -dist_c;
        if (dist_a <= dist_b && dist_a <= dist_c) return a;
        if (dist_b <= dist_c) return b;
        return c;
    endfunction

    // advances the mirrored state by one byte; returns 1 when the byte yields a pixel
    function automatic bit unfilter_byte(input logic [7:0] x, input logic st,
                                         output logic [7:0] px, output logic row_end);
        int         bpp;
        int         len;
        int         col;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [8:0] avg;
        bpp = (cfg_bpp == 0) ? 1 :
              (int'(cfg_bpp) > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(cfg_bpp);
        len = (cfg_row == 0) ? 1 :
              (int'(cfg_row) > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(cfg_row);
        px = '0;
        row_end = 1'b0;
        if (st) begin
            first_row_flag = 1'b1;
            want_filter = 1'b1;
        end
        if (want_filter) begin
            row_filter = x;
            want_filter = 1'b0;
            col_pos = 0;
            left_hist = '0;
            above_left_hist = '0;
            return 1'b0;
        end
        col = (col_pos >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_pos;
        a = left_hist[bpp-1];
        c = above_left_hist[bpp-1];
        b = first_row_flag ? 8'h00 : prior_line[col];
        avg = ({1'b0, a} + {1'b0, b}) >> 1;
        case (row_filter)
            8'(FILT_SUB):   px = x + a;
            8'(FILT_UP):    px = x + b;
            8'(FILT_AVG):   px = x + avg[7:0];
            8'(FILT_PAETH): px = x + paeth_pick(a, b, c);
            default:        px = x;
        endcase
        prior_line[col] = px;
        left_hist = {left_hist[MAX_PIXEL_BYTES-2:0], px};
        above_left_hist = {above_left_hist[MAX_PIXEL_BYTES-2:0], b};
        row_end = (col + 1 >= len);
        if (row_end) begin
            want_filter = 1'b1;
            first_row_flag = 1'b0;
            col_pos = 0;
        end else begin
            col_pos = col + 1;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic st, input bit known,
                             input logic [7:0] known_px, input logic known_end);
        logic [7:0] px;
        logic       row_end;
        pixel_exp_t e;
        if (src_gap_odds != 0 && $urandom_range(src_gap_odds, 1) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (unfilter_byte(d, st, px, row_end)) begin
            e.pixel   = known ? known_px : px;
            e.row_end = known ? known_end : row_end;
            pending_pixels.push_back(e);
        end
    endtask

    task automatic send_row(input logic [7:0] filt, input logic st, input int ndata);
        int k;
        push_byte(filt, st, 1'b0, 8'h00, 1'b0);
        for (k = 0; k < ndata; k++) push_byte(rand_byte(), 1'b0, 1'b0, 8'h00, 1'b0);
    endtask

    // stop sending and let every outstanding pixel come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        if (idx == REG_BYTES_PER_PIXEL) cfg_bpp = BPP_W'(val);
        else if (idx == REG_ROW_BYTES) cfg_row = LEN_W'(val);
        reg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input phase_t ph);
        int         first_byte;
        int         rows;
        int         len;
        int         cut;
        int         r;
        logic [7:0] filt;
        drain_results();
        src_gap_odds  = ph.src_gap_odds;
        sink_gap_odds = ph.sink_gap_odds;
        write_reg(REG_BYTES_PER_PIXEL, ph.bpp);
        write_reg(REG_ROW_BYTES, ph.row);
        len = (ph.row == 0) ? 1 : (ph.row > MAX_ROW_BYTES) ? MAX_ROW_BYTES : ph.row;
        first_byte = bytes_sent;
        do begin
            rows = $urandom_range(ph.max_rows, ph.min_rows);
            for (r = 0; r < rows; r++) begin
                if ($urandom_range(9, 0) == 0) filt = 8'($urandom);
                else filt = 8'($urandom_range(FILT_PAETH, FILT_NONE));
                cut = len;
                // a short row, after which a fresh image starts
                if ($urandom_range(24, 0) == 0) cut = $urandom_range(len - 1, 0);
                send_row(filt, r == 0, cut);
                if (cut != len) break;
            end
        end while (bytes_sent - first_byte < ph.min_bytes);
    endtask

    // row length shrinks below the current column, so the next data byte closes the row
    task automatic shrink_row_midway();
        drain_results();
        src_gap_odds  = 6;
        sink_gap_odds = 6;
        write_reg(REG_BYTES_PER_PIXEL, 2);
        write_reg(REG_ROW_BYTES, 12);
        send_row(8'(FILT_SUB), 1'b1, 12);
        send_row(8'(FILT_PAETH), 1'b0, 7);
        drain_results();
        write_reg(REG_ROW_BYTES, 4);
        push_byte(rand_byte(), 1'b0, 1'b0, 8'h00, 1'b0);
        send_row(8'(FILT_UP), 1'b0, 4);
        send_row(8'(FILT_AVG), 1'b0, 4);
        send_row(8'(FILT_PAETH), 1'b0, 4);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected output transfer, expected none, got %02h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                head_exp = pending_pixels.pop_front();
                bytes_checked++;
                if (m_tdata !== head_exp.pixel) begin
                    $display("%0t: pixel byte expected %02h, got %02h",
                             $time, head_exp.pixel, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== head_exp.row_end) begin
                    $display("%0t: row last expected %b, got %b",
                             $time, head_exp.row_end, m_tlast);
                    mismatches++;
                end
            end
        end
        if (sink_gap != 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if (sink_gap_odds != 0 && $urandom_range(sink_gap_odds, 1) == 1) begin
            sink_gap = $urandom_range(15, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d pixels outstanding", $time,
                     pending_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_gap_odds  = 8;
        sink_gap_odds = 8;
        foreach (directed_rows[i]) begin
            push_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].known,
                      directed_rows[i].pixel, directed_rows[i].row_end);
        end
        foreach (phase_list[i]) run_phase(phase_list[i]);
        shrink_row_midway();
        // last stretch runs with both sides always ready
        run_phase('{3, 9, 150, 1, 6, 0, 0});
        drain_results();
        $display("sent %0d bytes, checked %0d reconstructed bytes", bytes_sent, bytes_checked);
        $display("over %0d register writes, all five filters, odd codes and image restarts",
                 reg_writes);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pngu_pkg.sv
rtl/core/pngu_ram.sv
rtl/core/pngu_front.sv
rtl/core/pngu_queue.sv
rtl/core/pngu_back.sv
rtl/core/png_scanline_unfilter.sv
tb/sv/tb_top.sv
